// ----- rtl/sgd_pkg.sv -----
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared types, codes and reset values of the swipe gesture detector.
// ----------------------------------------------------------------------------
package sgd_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DELTA_W  = COORD_W + 1;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned ACC_W    = 18;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [MS_W-1:0]  MS_MAX  = '1;

  localparam logic [14:0] MIN_STEP_RST  = 15'd287;
  localparam logic [15:0] THRESHOLD_RST = 16'd1229;
  localparam logic [15:0] COOLDOWN_RST  = 16'd700;

  localparam logic [CNT_W-1:0] ONE_POINT = 4'd1;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_TICK  = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_STEP  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_COOLDOWN  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef struct packed {
    req_t               req_type;
    logic [CNT_W-1:0]   point_count;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } item_t;

  typedef struct packed {
    logic fire;
    dir_t dir;
  } result_t;

endpackage

// ----- rtl/sgd_core.sv -----
// ----------------------------------------------------------------------------
// sgd_core
// Configuration registers, tracking state and the per-item update.
// ----------------------------------------------------------------------------
module sgd_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  logic [sgd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [sgd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                item_go,
  input  sgd_pkg::item_t                      item,
  output sgd_pkg::result_t                    res
);
  import sgd_pkg::*;

  logic [14:0]        min_step_r;
  logic [15:0]        threshold_r;
  logic [MS_W-1:0]    cooldown_r;

  logic [COORD_W-1:0] prev_x_r, prev_x_nxt;
  logic [COORD_W-1:0] prev_y_r, prev_y_nxt;
  logic               broken_r, broken_nxt;
  logic               started_r, started_nxt;
  logic [MS_W-1:0]    elapsed_r, elapsed_nxt;
  logic [ACC_W-1:0]   acc_r   [4];
  logic [ACC_W-1:0]   acc_nxt [4];

  logic signed [DELTA_W-1:0] dx, dy;
  logic [DELTA_W-1:0]        dx_abs, dy_abs;
  logic [MAG_W-1:0]          ax, ay, mag;
  logic                      step_ok;
  dir_t                      dir;
  logic [ACC_W-1:0]          acc_sel;
  logic [ACC_W:0]            sum;
  logic [ACC_W-1:0]          acc_sat;
  logic                      fire;

  // Motion datapath
  always_comb begin
    dx = $signed({item.point_x[COORD_W-1], item.point_x})
       - $signed({prev_x_r[COORD_W-1], prev_x_r});
    dy = $signed({item.point_y[COORD_W-1], item.point_y})
       - $signed({prev_y_r[COORD_W-1], prev_y_r});
    dx_abs = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
    dy_abs = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
    ax = dx_abs[MAG_W-1:0];
    ay = dy_abs[MAG_W-1:0];
    if (ax > ay) begin
      mag = ax;
      dir = dx[DELTA_W-1] ? DIR_RIGHT : DIR_LEFT;
    end else begin
      mag = ay;
      dir = dy[DELTA_W-1] ? DIR_UP : DIR_DOWN;
    end
    step_ok = (mag > {1'b0, min_step_r});
    acc_sel = acc_r[dir];
    sum     = {1'b0, acc_sel} + {{(ACC_W+1-MAG_W){1'b0}}, mag};
    acc_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    fire    = (acc_sat >= {{(ACC_W-16){1'b0}}, threshold_r});
  end

  // State update
  always_comb begin
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    broken_nxt  = broken_r;
    started_nxt = started_r;
    elapsed_nxt = elapsed_r;
    acc_nxt     = acc_r;
    res.fire    = 1'b0;
    res.dir     = dir;
    if (item_go) begin
      if (item.req_type == REQ_TICK) begin
        if (started_r && elapsed_r != MS_MAX) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end else begin
        if (!started_r) begin
          started_nxt = 1'b1;
          elapsed_nxt = '0;
        end
        if (item.point_count != ONE_POINT) begin
          broken_nxt = 1'b1;
        end else begin
          prev_x_nxt = item.point_x;
          prev_y_nxt = item.point_y;
          if (broken_r) begin
            broken_nxt = 1'b0;
          end else if (elapsed_r >= cooldown_r && step_ok) begin
            for (int i = 0; i < 4; i++) begin
              acc_nxt[i] = '0;
            end
            if (fire) begin
              res.fire    = 1'b1;
              elapsed_nxt = '0;
            end else begin
              acc_nxt[dir] = acc_sat;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r  <= MIN_STEP_RST;
      threshold_r <= THRESHOLD_RST;
      cooldown_r  <= COOLDOWN_RST;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      broken_r    <= 1'b1;
      started_r   <= 1'b0;
      elapsed_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
      broken_r  <= broken_nxt;
      started_r <= started_nxt;
      elapsed_r <= elapsed_nxt;
      acc_r     <= acc_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_MIN_STEP:  min_step_r  <= cfg_wdata[14:0];
          CFG_THRESHOLD: threshold_r <= cfg_wdata;
          CFG_COOLDOWN:  cooldown_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/swipe_gesture_detector_top.sv -----
// ----------------------------------------------------------------------------
// swipe_gesture_detector_top
// Swipe detector for one tracked point: input register, update, result reg.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   carries frames (req_type 0: point count and one Q3.12 point) and
//          millisecond ticks (req_type 1). A transfer happens when in_valid
//          and in_ready are both high.
//   out_*  carries one swipe direction per detected swipe; most items make
//          no result at all.
//   cfg_*  writes min_step (0), swipe_threshold (1) and cooldown_ms (2);
//          cfg_ready is always high. Write only while the block is idle.
// Flow: the input transfer loads the input register, the update runs from
//   there, and a swipe is loaded into the result register once that register
//   can take a value, which raises out_valid.
// Throughput: one item per cycle while no result is stalled; the update is a
//   single pass of a 17-bit subtract, 18-bit saturating add and a few compares.
// Reset (rst_n low, synchronous): both stages empty, accumulators and the
//   ms counter cleared, the motion chain marked broken, registers to their
//   defaults. A stalled receiver holds the result; the input register then
//   holds one more item and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module swipe_gesture_detector_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [3:0]                        in_point_count,
  input  logic signed [15:0]                in_point_x,
  input  logic signed [15:0]                in_point_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_swipe_dir,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sgd_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    s1_go;
  logic    out_valid_r, out_valid_nxt;
  logic [1:0] out_dir_r;
  result_t res;

  // Advance the input register whenever the result register can take a value
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;  // drop a taken result
    end
    if (s1_go && res.fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  sgd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .item_go   (s1_go),
    .item      (s1_item_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type    <= req_t'(in_req_type);
      s1_item_r.point_count <= in_point_count;
      s1_item_r.point_x     <= in_point_x;
      s1_item_r.point_y     <= in_point_y;
    end
    if (s1_go && res.fire) begin
      out_dir_r <= res.dir;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_swipe_dir = out_dir_r;

  // Input stalls only when both stages are full and the receiver stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full, stalled pipeline");

  // A new result always comes from an item in the input register
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an item");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after transfer");

endmodule
